FILE: design/btxq_pkg.sv
package btxq_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODE_COUNT = 65536;
  localparam int COUNT_BITS = 24;

  localparam int NODE_BITS = $clog2(NODE_COUNT);
  localparam int STEP_BITS = $clog2(KEY_BITS + 1);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_REMOVE     = 3'd1;
  localparam logic [2:0] OP_REMOVE_ALL = 3'd2;
  localparam logic [2:0] OP_MIN_XOR    = 3'd3;
  localparam logic [2:0] OP_MAX_XOR    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [2:0]          op;
    logic [KEY_BITS-1:0] key;
  } req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] answer;
    logic [1:0]          status;
  } rsp_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]  zero_child;
    logic [NODE_BITS-1:0]  one_child;
    logic [COUNT_BITS-1:0] count;
  } node_t;

  typedef struct packed {
    logic                 we;
    logic [NODE_BITS-1:0] wr_addr;
    node_t                wr_data;
    logic [NODE_BITS-1:0] rd_addr_a;
    logic [NODE_BITS-1:0] rd_addr_b;
  } ram_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CAP,
    S_REM_FIND,
    S_UPD,
    S_QRY_START,
    S_QRY
  } state_t;

endpackage

FILE: design/btxq_ram.sv
module btxq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: design/btxq_walker.sv
module btxq_walker
  import btxq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  req_t     req,
  output logic     busy,
  output logic     done,
  output rsp_t     rsp,
  output ram_req_t ram_req,
  input  node_t    rd_a,
  input  node_t    rd_b
);

  state_t state, state_next;

  logic [2:0]            op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [KEY_BITS-1:0]   key_sh;
  logic [STEP_BITS-1:0]  step;
  logic [NODE_BITS-1:0]  nodes_used;
  logic [NODE_BITS-1:0]  root_zero;
  logic [NODE_BITS-1:0]  root_one;
  logic [NODE_BITS-1:0]  cur_idx;
  logic                  cur_new;
  logic [COUNT_BITS-1:0] amount;
  logic [NODE_BITS-1:0]  link0;
  logic [NODE_BITS-1:0]  link1;
  logic [KEY_BITS-1:0]   ans;

  // Shared decision terms.
  node_t                 cur_e;
  logic                  cur_bit;
  logic                  at_leaf;
  logic [NODE_BITS-1:0]  nx_link;
  logic [NODE_BITS-1:0]  new_idx;
  logic [STEP_BITS-1:0]  needed;
  logic                  pool_over;
  logic                  chk_full;
  logic                  is_ins;
  logic                  upd_alloc;
  logic [NODE_BITS-1:0]  upd_link;
  node_t                 upd_e;
  logic                  want_max;
  logic [COUNT_BITS-1:0] cnt0;
  logic [COUNT_BITS-1:0] cnt1;
  logic                  pref;
  logic                  take_pref;
  logic                  dir;
  node_t                 chosen;
  logic                  abit;
  logic                  q_empty;
  logic                  q_last;

  logic                fin;
  logic [1:0]          fin_status;
  logic [KEY_BITS-1:0] fin_answer;

  always_comb begin
    if (step == '0) begin
      cur_e = '{zero_child: root_zero, one_child: root_one, count: '0};
    end else if (cur_new) begin
      cur_e = '0;
    end else begin
      cur_e = rd_a;
    end
    cur_bit   = key_sh[KEY_BITS-1];
    at_leaf   = (step == STEP_BITS'(KEY_BITS));
    nx_link   = cur_bit ? cur_e.one_child : cur_e.zero_child;
    new_idx   = nodes_used + NODE_BITS'(1);
    needed    = STEP_BITS'(KEY_BITS) - step;
    pool_over = ({1'b0, nodes_used} + (NODE_BITS+1)'(needed))
                > (NODE_BITS+1)'(NODE_COUNT - 1);
    chk_full  = (step != '0) && (cur_e.count == CNT_MAX);

    is_ins    = (op_r == OP_INSERT);
    upd_alloc = is_ins && (nx_link == '0) && !at_leaf;
    upd_link  = upd_alloc ? new_idx : nx_link;
    upd_e     = cur_e;
    if (cur_bit) begin
      upd_e.one_child = upd_link;
    end else begin
      upd_e.zero_child = upd_link;
    end
    if (is_ins) begin
      upd_e.count = cur_e.count + COUNT_BITS'(1);
    end else if (cur_e.count >= amount) begin
      upd_e.count = cur_e.count - amount;
    end else begin
      upd_e.count = '0;
    end

    // A missing link counts as an empty subtree.
    want_max  = (op_r == OP_MAX_XOR);
    cnt0      = (link0 != '0) ? rd_a.count : '0;
    cnt1      = (link1 != '0) ? rd_b.count : '0;
    pref      = cur_bit ^ want_max;
    take_pref = pref ? (cnt1 != '0) : (cnt0 != '0);
    dir       = take_pref ? pref : !pref;
    chosen    = dir ? rd_b : rd_a;
    abit      = take_pref ? want_max : !want_max;
    q_empty   = (cnt0 == '0) && (cnt1 == '0);
    q_last    = (step == STEP_BITS'(KEY_BITS - 1));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req.op)
            OP_INSERT:                 state_next = S_INS_CHK;
            OP_REMOVE, OP_REMOVE_ALL:  state_next = S_REM_FIND;
            OP_MIN_XOR, OP_MAX_XOR:    state_next = S_QRY_START;
            default:                   state_next = S_IDLE;
          endcase
        end
      end
      S_INS_CHK: begin
        if (chk_full) begin
          state_next = S_IDLE;
        end else if (at_leaf || nx_link == '0) begin
          state_next = S_INS_CAP;
        end
      end
      S_INS_CAP: begin
        state_next = pool_over ? S_IDLE : S_UPD;
      end
      S_REM_FIND: begin
        if (at_leaf) begin
          state_next = (cur_e.count == '0) ? S_IDLE : S_UPD;
        end else if (nx_link == '0) begin
          state_next = S_IDLE;
        end
      end
      S_UPD: begin
        if (at_leaf) begin
          state_next = S_IDLE;
        end
      end
      S_QRY_START: state_next = S_QRY;
      S_QRY: begin
        if ((step == '0 && q_empty) || q_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_req    = '0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_answer = '0;
    case (state)
      S_IDLE: begin
        fin = start && !(req.op inside {OP_INSERT, OP_REMOVE, OP_REMOVE_ALL,
                                        OP_MIN_XOR, OP_MAX_XOR});
      end
      S_INS_CHK: begin
        ram_req.rd_addr_a = nx_link;
        fin               = chk_full;
        fin_status        = ST_FULL;
      end
      S_INS_CAP: begin
        fin        = pool_over;
        fin_status = ST_FULL;
      end
      S_REM_FIND: begin
        ram_req.rd_addr_a = nx_link;
        fin        = at_leaf ? (cur_e.count == '0) : (nx_link == '0);
        fin_status = ST_NOT_FOUND;
      end
      S_UPD: begin
        // The root lives in registers; every other node on the path is
        // rewritten once while the next one is being read.
        ram_req.rd_addr_a = nx_link;
        ram_req.we        = (step != '0);
        ram_req.wr_addr   = cur_idx;
        ram_req.wr_data   = upd_e;
        fin               = at_leaf;
      end
      S_QRY_START: begin
        ram_req.rd_addr_a = root_zero;
        ram_req.rd_addr_b = root_one;
      end
      S_QRY: begin
        ram_req.rd_addr_a = chosen.zero_child;
        ram_req.rd_addr_b = chosen.one_child;
        if (step == '0 && q_empty) begin
          fin        = 1'b1;
          fin_status = ST_EMPTY;
        end else if (q_last) begin
          fin        = 1'b1;
          fin_answer = (ans << 1) | KEY_BITS'(abit);
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      nodes_used <= '0;
      root_zero  <= '0;
      root_one   <= '0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (fin) begin
        rsp.answer <= fin_answer;
        rsp.status <= fin_status;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r    <= req.op;
            key_r   <= req.key;
            key_sh  <= req.key;
            step    <= '0;
            cur_new <= 1'b0;
          end
        end
        S_INS_CHK: begin
          if (!chk_full && !at_leaf && nx_link != '0) begin
            step   <= step + STEP_BITS'(1);
            key_sh <= key_sh << 1;
          end
        end
        S_INS_CAP: begin
          step    <= '0;
          key_sh  <= key_r;
          cur_new <= 1'b0;
        end
        S_REM_FIND: begin
          if (at_leaf) begin
            amount  <= (op_r == OP_REMOVE_ALL) ? cur_e.count : COUNT_BITS'(1);
            step    <= '0;
            key_sh  <= key_r;
            cur_new <= 1'b0;
          end else begin
            step   <= step + STEP_BITS'(1);
            key_sh <= key_sh << 1;
          end
        end
        S_UPD: begin
          if (!at_leaf) begin
            if (step == '0) begin
              root_zero <= upd_e.zero_child;
              root_one  <= upd_e.one_child;
            end
            if (upd_alloc) begin
              nodes_used <= new_idx;
            end
            cur_idx <= upd_link;
            cur_new <= upd_alloc;
            step    <= step + STEP_BITS'(1);
            key_sh  <= key_sh << 1;
          end
        end
        S_QRY_START: begin
          step  <= '0;
          ans   <= '0;
          link0 <= root_zero;
          link1 <= root_one;
        end
        S_QRY: begin
          ans    <= (ans << 1) | KEY_BITS'(abit);
          link0  <= chosen.zero_child;
          link1  <= chosen.one_child;
          step   <= step + STEP_BITS'(1);
          key_sh <= key_sh << 1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/binary_trie_xor_query.sv
// Channel   Handshake                 Payload
// request   start in, busy out        req.op, req.key
// result    done out (one cycle)      rsp.answer, rsp.status
//
// A request is taken when start is high and busy is low; its result appears
// with done for one cycle once the walk ends, and busy is already low then.
// Insert runs a check walk, a pool check and an update walk, remove a find
// walk and an update walk, a query one walk; each walk makes one dependent
// read of the node RAM per trie level. Reset clears the root links and the node
// allocator only, so no clearing pass is run. The result side cannot stall.
module binary_trie_xor_query
  import btxq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  ram_req_t              ram_req;
  logic [$bits(node_t)-1:0] rd_data_a;
  logic [$bits(node_t)-1:0] rd_data_b;
  node_t                 rd_a;
  node_t                 rd_b;

  assign rd_a = rd_data_a;
  assign rd_b = rd_data_b;

  btxq_ram #(
    .WIDTH($bits(node_t)),
    .DEPTH(NODE_COUNT)
  ) u_ram (
    .clk      (clk),
    .we       (ram_req.we),
    .wr_addr  (ram_req.wr_addr),
    .wr_data  (ram_req.wr_data),
    .rd_addr_a(ram_req.rd_addr_a),
    .rd_addr_b(ram_req.rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  btxq_walker u_walker (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .rsp    (rsp),
    .ram_req(ram_req),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

  // The root is held in registers, so the RAM is never written at node zero.
  a_no_root_write: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> ram_req.wr_addr != '0)
    else $error("node RAM written at the root index");

  // During an update the node being rewritten is never the one being read.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> ram_req.rd_addr_a != ram_req.wr_addr)
    else $error("node RAM read and written at the same entry");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while a request is still in progress");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted request neither started nor finished");

endmodule

FILE: tb/sv/binary_trie_xor_query_tb.sv
module binary_trie_xor_query_tb
  import btxq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 80;

  localparam logic [2:0]          OP_CODE_TOP  = 3'b111;
  localparam logic [KEY_BITS-1:0] KEY_ALL_ONES = {KEY_BITS{1'b1}};

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t rsp;

  binary_trie_xor_query i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Shadow trie: child links, occupancy counts and the allocator.
  bit [NODE_BITS-1:0]  zero_kid  [NODE_COUNT];
  bit [NODE_BITS-1:0]  one_kid   [NODE_COUNT];
  bit [COUNT_BITS-1:0] occupancy [NODE_COUNT];
  int                  pool_used = 0;

  rsp_t                pending_results [$];
  logic [KEY_BITS-1:0] stored_keys [$];
  int                  mismatch_count = 0;
  bit                  gaps_on = 1'b1;

  function automatic int kid_of(input int node, input bit b);
    return b ? int'(one_kid[node]) : int'(zero_kid[node]);
  endfunction

  function automatic rsp_t trie_apply(input req_t r);
    rsp_t                res;
    int                  node;
    int                  nx;
    int                  needed;
    bit                  want_max;
    bit                  p;
    logic [COUNT_BITS-1:0] amount;
    res.answer = '0;
    res.status = ST_OK;
    case (r.op)
      OP_INSERT: begin
        // The first walk only checks that the insert can be done at all.
        node   = 0;
        needed = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
          nx = kid_of(node, r.key[i]);
          if (nx == 0) begin
            needed = i + 1;
            break;
          end
          if (occupancy[nx] == CNT_MAX) begin
            res.status = ST_FULL;
            return res;
          end
          node = nx;
        end
        if (pool_used + needed > NODE_COUNT - 1) begin
          res.status = ST_FULL;
          return res;
        end
        node = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
          nx = kid_of(node, r.key[i]);
          if (nx == 0) begin
            pool_used++;
            nx = pool_used;
            if (r.key[i]) one_kid[node] = nx[NODE_BITS-1:0];
            else zero_kid[node] = nx[NODE_BITS-1:0];
          end
          node = nx;
          occupancy[node] = occupancy[node] + 1'b1;
        end
      end
      OP_REMOVE, OP_REMOVE_ALL: begin
        node = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
          node = kid_of(node, r.key[i]);
          if (node == 0) break;
        end
        if (node == 0 || occupancy[node] == 0) begin
          res.status = ST_NOT_FOUND;
          return res;
        end
        amount = (r.op == OP_REMOVE_ALL) ? occupancy[node] : COUNT_BITS'(1);
        node = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
          node = kid_of(node, r.key[i]);
          if (node == 0) break;
          if (occupancy[node] >= amount) occupancy[node] = occupancy[node] - amount;
          else occupancy[node] = '0;
        end
      end
      OP_MIN_XOR, OP_MAX_XOR: begin
        want_max = (r.op == OP_MAX_XOR);
        if (occupancy[zero_kid[0]] == 0 && occupancy[one_kid[0]] == 0) begin
          res.status = ST_EMPTY;
          return res;
        end
        node = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
          p  = r.key[i] ^ want_max;
          nx = kid_of(node, p);
          if (nx != 0 && occupancy[nx] != 0) begin
            res.answer[i] = want_max;
          end else begin
            res.answer[i] = !want_max;
            nx = kid_of(node, !p);
          end
          node = nx;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Mostly keys already stored or one bit away from them, so that removals
  // hit and paths are shared deep into the trie.
  function automatic logic [KEY_BITS-1:0] pick_key();
    int                  pick;
    logic [KEY_BITS-1:0] base;
    pick = $urandom_range(0, 99);
    if (stored_keys.size() != 0) base = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    else base = KEY_BITS'($urandom());
    if (pick < 40) return base;
    if (pick < 60) return base ^ (KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1));
    if (pick < 75) return KEY_BITS'($urandom_range(0, 15));
    if (pick < 85) return {4'($urandom()), {(KEY_BITS - 4){1'b0}}} | KEY_BITS'($urandom_range(0, 3));
    return KEY_BITS'($urandom());
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [KEY_BITS-1:0] key,
                              output rsp_t want);
    int   gap;
    int   pick;
    req_t r;
    r.op  = op;
    r.key = key;
    gap   = 0;
    if (gaps_on) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 20);
      else gap = $urandom_range(40, 200);
    end
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      req   <= {3'($urandom()), KEY_BITS'($urandom())};
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    want = trie_apply(r);
    pending_results.push_back(want);
    if (op == OP_INSERT && want.status == ST_OK) stored_keys.push_back(key);
  endtask

  task automatic test_directed_cases();
    rsp_t got;
    send_request(OP_MIN_XOR, '0, got);
    send_request(OP_MAX_XOR, KEY_ALL_ONES, got);
    send_request(OP_REMOVE, '0, got);
    send_request(OP_REMOVE_ALL, KEY_ALL_ONES, got);
    send_request(OP_INSERT, '0, got);
    send_request(OP_INSERT, KEY_ALL_ONES, got);
    send_request(OP_INSERT, '0, got);
    send_request(OP_MIN_XOR, '0, got);
    send_request(OP_MAX_XOR, '0, got);
    send_request(OP_MIN_XOR, KEY_ALL_ONES, got);
    send_request(OP_MAX_XOR, 31'h5555_5555, got);
    // Key 1 shares all but the last level with key 0.
    send_request(OP_REMOVE, 31'h0000_0001, got);
    send_request(OP_REMOVE, '0, got);
    send_request(OP_MIN_XOR, '0, got);
    send_request(OP_INSERT, '0, got);
    send_request(OP_INSERT, '0, got);
    send_request(OP_REMOVE_ALL, '0, got);
    // The all-ones key must still be visible after every copy of key 0 was removed.
    send_request(OP_MIN_XOR, '0, got);
    send_request(OP_REMOVE, '0, got);
    for (int c = OP_MAX_XOR + 1; c <= OP_CODE_TOP; c++) begin
      send_request(3'(c), KEY_BITS'($urandom()), got);
    end
    send_request(OP_REMOVE_ALL, KEY_ALL_ONES, got);
    send_request(OP_MAX_XOR, 31'h2AAA_AAAA, got);
    send_request(OP_INSERT, 31'h2AAA_AAAA, got);
  endtask

  task automatic test_random_traffic(input int n_items);
    rsp_t       got;
    int         pick;
    logic [2:0] op;
    for (int n = 0; n < n_items; n++) begin
      if (n % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_INSERT;
      else if (pick < 50) op = OP_REMOVE;
      else if (pick < 60) op = OP_REMOVE_ALL;
      else if (pick < 77) op = OP_MIN_XOR;
      else if (pick < 94) op = OP_MAX_XOR;
      else op = 3'($urandom_range(OP_MAX_XOR + 1, OP_CODE_TOP));
      send_request(op, pick_key(), got);
    end
  endtask

  // Removes every key ever stored, so the queries at the end see an empty
  // store even though its nodes are still allocated.
  task automatic test_drain_store();
    rsp_t                got;
    logic [KEY_BITS-1:0] keys [$];
    keys = stored_keys;
    gaps_on = 1'b1;
    foreach (keys[n]) send_request(OP_REMOVE_ALL, keys[n], got);
    send_request(OP_MIN_XOR, KEY_BITS'($urandom()), got);
    send_request(OP_MAX_XOR, KEY_BITS'($urandom()), got);
    stored_keys.delete();
  endtask

  // Keys with bit-reversed prefixes branch as early as possible, so each
  // insert takes many fresh nodes. The pool is far larger than a run of this
  // length can fill, and count saturation would need 2^24 - 1 copies of one key,
  // so neither refusal is reached here.
  task automatic test_fresh_paths();
    rsp_t                got;
    logic [11:0]         prefix;
    logic [KEY_BITS-1:0] k;
    gaps_on = 1'b0;
    for (int j = 0; j < 150; j++) begin
      for (int b = 0; b < 12; b++) prefix[b] = j[11 - b];
      k = {prefix, 19'($urandom())};
      send_request(OP_INSERT, k, got);
      if (j % 32 == 31) send_request(OP_MAX_XOR, KEY_BITS'($urandom()), got);
    end
    // Neighbours need at most three fresh nodes near the leaves.
    gaps_on = 1'b1;
    for (int n = 0; n < 50; n++) begin
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      send_request(OP_INSERT, k ^ (KEY_BITS'(1) << $urandom_range(0, 2)), got);
    end
    test_random_traffic(100);
  endtask

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: answer %h status %0d",
               rsp.answer, rsp.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.answer !== want.answer) begin
          $error("answer: expected %h, got %h", want.answer, rsp.answer);
          mismatch_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic(450);
    test_drain_store();
    test_random_traffic(250);
    test_fresh_paths();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
